// ===== rtl/i2cm_pkg.sv =====
`timescale 1ns / 1ps
package i2cm_pkg;

   typedef enum logic [23:0] {
      PH_IDLE     = 24'h000001,
      PH_ST_A     = 24'h000002,
      PH_ST_B     = 24'h000004,
      PH_ST_C     = 24'h000008,
      PH_ST_D     = 24'h000010,
      PH_W_PRE    = 24'h000020,
      PH_W_SET    = 24'h000040,
      PH_W_HIGH   = 24'h000080,
      PH_W_LOW    = 24'h000100,
      PH_A1       = 24'h000200,
      PH_A2       = 24'h000400,
      PH_AW       = 24'h000800,
      PH_A3       = 24'h001000,
      PH_A4       = 24'h002000,
      PH_R_PRE    = 24'h004000,
      PH_R_HIGH   = 24'h008000,
      PH_R_LOW    = 24'h010000,
      PH_K_SET    = 24'h020000,
      PH_K_HIGH   = 24'h040000,
      PH_K_LOW    = 24'h080000,
      PH_P_A      = 24'h100000,
      PH_P_B      = 24'h200000,
      PH_RETRY    = 24'h400000,
      PH_WAITBYTE = 24'h800000
   } phase_type;

   localparam logic [2:0] SG_ADDR1 = 3'd0;
   localparam logic [2:0] SG_REG   = 3'd1;
   localparam logic [2:0] SG_RADDR = 3'd2;
   localparam logic [2:0] SG_WDATA = 3'd3;
   localparam logic [2:0] SG_RDATA = 3'd4;

   localparam logic [1:0] KIND_BEGIN = 2'd1;
   localparam logic [1:0] KIND_BYTE  = 2'd2;

   localparam logic [2:0] TT_REG_WRITE   = 3'd0;
   localparam logic [2:0] TT_REG_READ    = 3'd1;
   localparam logic [2:0] TT_PLAIN_READ  = 3'd3;
   localparam logic [2:0] TT_CMD_WRITE   = 3'd4;

   localparam logic [1:0] REG_SHORT = 2'd0;
   localparam logic [1:0] REG_LONG  = 2'd1;
   localparam logic [1:0] REG_RETRY = 2'd2;
   localparam logic [1:0] REG_ACKW  = 2'd3;

   typedef struct packed {
      logic [15:0] short_ticks;
      logic [15:0] long_ticks;
      logic [23:0] retry_ticks;
      logic [7:0]  ack_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [23:0] timer;
      logic [3:0]  bitc;
      logic [7:0]  shreg;
      logic [7:0]  bleft;
      logic [2:0]  ltype;
      logic [7:0]  ldev;
      logic [7:0]  lreg;
      logic        retried;
      logic        ack;
      logic [2:0]  stage;
      logic        scl;
      logic        sda;
      logic        cur_sda;
      logic        emit;
      logic        done;
   } eng_type;

   function automatic logic [23:0] dur_short(input cfg_type c);
      return (c.short_ticks == 16'd0) ? 24'd1 : {8'd0, c.short_ticks};
   endfunction

   function automatic logic [23:0] dur_long(input cfg_type c);
      return (c.long_ticks == 16'd0) ? 24'd1 : {8'd0, c.long_ticks};
   endfunction

   function automatic eng_type enter(input eng_type si, input phase_type p, input cfg_type c);
      eng_type s;
      s = si;
      s.phase = p;
      s.timer = dur_short(c);
      unique case (p)
         PH_ST_A: s.sda = 1'b1;
         PH_ST_B: s.scl = 1'b1;
         PH_ST_C: s.sda = 1'b0;
         PH_ST_D: s.scl = 1'b0;
         PH_W_PRE: begin
            s.scl  = 1'b0;
            s.bitc = 4'd0;
         end
         PH_W_SET: s.sda = s.shreg[7];
         PH_W_HIGH: begin
            s.scl   = 1'b1;
            s.timer = dur_long(c);
         end
         PH_W_LOW: s.scl = 1'b0;
         PH_A1: begin
            s.scl = 1'b0;
            s.sda = 1'b1;
         end
         PH_A2: begin
            s.scl = 1'b1;
            s.sda = 1'b1;
         end
         PH_AW: begin
            s.ack   = 1'b0;
            s.timer = {16'd0, c.ack_ticks};
         end
         PH_A3: ;
         PH_A4: s.scl = 1'b0;
         PH_R_PRE: begin
            s.sda   = 1'b1;
            s.bitc  = 4'd0;
            s.shreg = 8'd0;
         end
         PH_R_HIGH: begin
            s.scl   = 1'b1;
            s.shreg = {s.shreg[6:0], s.cur_sda};
            s.bitc  = s.bitc + 4'd1;
            if (s.bitc == 4'd8) s.emit = 1'b1;
         end
         PH_R_LOW: begin
            s.scl   = 1'b0;
            s.timer = dur_long(c);
         end
         PH_K_SET: begin
            if (s.bleft != 8'd0) s.bleft = s.bleft - 8'd1;
            s.sda = (s.bleft == 8'd0);
         end
         PH_K_HIGH: begin
            s.scl   = 1'b1;
            s.timer = dur_long(c);
         end
         PH_K_LOW: s.scl = 1'b0;
         PH_P_A: s.sda = 1'b0;
         PH_P_B: s.scl = 1'b1;
         PH_RETRY: s.timer = c.retry_ticks;
         PH_WAITBYTE: begin
            s.scl   = 1'b0;
            s.timer = 24'd0;
         end
         default: begin
            s.phase = PH_IDLE;
            s.scl   = 1'b1;
            s.sda   = 1'b1;
            s.timer = 24'd0;
         end
      endcase
      return s;
   endfunction

   function automatic eng_type stop_with(input eng_type si, input logic ok, input cfg_type c);
      eng_type s;
      s = si;
      s.ack = ok;
      return enter(s, PH_P_A, c);
   endfunction

   function automatic eng_type to_write(input eng_type si, input cfg_type c);
      eng_type s;
      s = si;
      s.stage = SG_WDATA;
      if (s.bleft == 8'd0) return stop_with(s, 1'b1, c);
      return enter(s, PH_WAITBYTE, c);
   endfunction

   function automatic eng_type after_ack(input eng_type si, input cfg_type c);
      eng_type s;
      s = si;
      if (!s.ack) begin
         if (s.stage == SG_ADDR1 && s.ltype != TT_CMD_WRITE && !s.retried) begin
            s.retried = 1'b1;
            return enter(s, PH_RETRY, c);
         end
         return stop_with(s, 1'b0, c);
      end
      case (s.stage)
         SG_ADDR1: begin
            if (s.ltype <= TT_REG_READ) begin
               s.stage = SG_REG;
               s.shreg = s.lreg;
               s = enter(s, PH_W_PRE, c);
            end else if (s.ltype == TT_PLAIN_READ) begin
               s.stage = SG_RADDR;
               s = enter(s, PH_ST_A, c);
            end else begin
               s = to_write(s, c);
            end
         end
         SG_REG: begin
            if (s.ltype == TT_REG_WRITE) begin
               s = to_write(s, c);
            end else begin
               s.stage = SG_RADDR;
               s = enter(s, PH_ST_A, c);
            end
         end
         SG_RADDR: begin
            if (s.bleft == 8'd0) begin
               s = stop_with(s, 1'b1, c);
            end else begin
               s.stage = SG_RDATA;
               s = enter(s, PH_R_PRE, c);
            end
         end
         SG_WDATA: begin
            if (s.bleft != 8'd0) s.bleft = s.bleft - 8'd1;
            s = to_write(s, c);
         end
         default: s = stop_with(s, 1'b1, c);
      endcase
      return s;
   endfunction

   function automatic eng_type advance(input eng_type si, input cfg_type c);
      eng_type s;
      s = si;
      unique case (s.phase)
         PH_ST_A: s = enter(s, PH_ST_B, c);
         PH_ST_B: s = enter(s, PH_ST_C, c);
         PH_ST_C: s = enter(s, PH_ST_D, c);
         PH_ST_D: begin
            s.shreg = (s.stage == SG_RADDR) ? (s.ldev | 8'h01) : s.ldev;
            s = enter(s, PH_W_PRE, c);
         end
         PH_W_PRE:  s = enter(s, PH_W_SET, c);
         PH_W_SET:  s = enter(s, PH_W_HIGH, c);
         PH_W_HIGH: s = enter(s, PH_W_LOW, c);
         PH_W_LOW: begin
            s.shreg = {s.shreg[6:0], 1'b0};
            s.bitc  = s.bitc + 4'd1;
            s = enter(s, (s.bitc >= 4'd8) ? PH_A1 : PH_W_SET, c);
         end
         PH_A1: s = enter(s, PH_A2, c);
         PH_A2: s = enter(s, PH_AW, c);
         PH_AW: s = enter(s, PH_A3, c);
         PH_A3: s = enter(s, PH_A4, c);
         PH_A4: s = after_ack(s, c);
         PH_R_PRE:  s = enter(s, PH_R_HIGH, c);
         PH_R_HIGH: s = enter(s, PH_R_LOW, c);
         PH_R_LOW:  s = enter(s, (s.bitc >= 4'd8) ? PH_K_SET : PH_R_HIGH, c);
         PH_K_SET:  s = enter(s, PH_K_HIGH, c);
         PH_K_HIGH: s = enter(s, PH_K_LOW, c);
         PH_K_LOW: begin
            if (s.bleft == 8'd0) s = stop_with(s, 1'b1, c);
            else s = enter(s, PH_R_PRE, c);
         end
         PH_P_A: s = enter(s, PH_P_B, c);
         PH_P_B: begin
            s.done = 1'b1;
            s = enter(s, PH_IDLE, c);
         end
         PH_RETRY: begin
            s.stage = SG_ADDR1;
            s = enter(s, PH_ST_A, c);
         end
         default: s = enter(s, PH_IDLE, c);
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/i2c_master_transaction_engine.sv =====
`timescale 1ns / 1ps
// Open-drain I2C master sequencer that takes one bus tick per transfer and returns one
// result per tick; a new tick is accepted every clock cycle while the result register is
// free or being drained. Each tick carries the sampled SDA level and an optional command
// (begin, or next write byte). The result gives the SCL/SDA release levels, a byte request
// while the engine holds SCL low waiting for data, received bytes, and busy/done/success.
// Phase lengths, the retry wait and the ack window are set through the APB registers.
module i2c_master_transaction_engine (
   input  logic        clock,
   input  logic        reset,
   // tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   // tdata: transfer_type[2:0], device_address[10:3], register_address[18:11],
   //        byte_count[26:19], write_byte[34:27], sda_in[35], zero fill [39:36]
   input  logic [39:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: scl_release[0], sda_release[1], byte_request[2], read_byte[10:3],
   //        read_valid[11], busy_res[12], done_res[13], success[14], zero fill [15]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import i2cm_pkg::*;

   cfg_type     cfg_ff;
   eng_type     eng_ff, eng_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff;
   logic        accept;

   logic [1:0]  kind;
   logic [2:0]  ttype;
   logic [7:0]  dev, regb, cnt, wbyte;
   logic        sda_in;

   assign kind   = req_tuser;
   assign ttype  = req_tdata[2:0];
   assign dev    = req_tdata[10:3];
   assign regb   = req_tdata[18:11];
   assign cnt    = req_tdata[26:19];
   assign wbyte  = req_tdata[34:27];
   assign sda_in = req_tdata[35];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      eng_type s;
      s = eng_ff;
      s.cur_sda = sda_in;
      s.emit    = 1'b0;
      s.done    = 1'b0;
      if (s.phase == PH_IDLE) begin
         if (kind == KIND_BEGIN && ttype <= TT_CMD_WRITE) begin
            s.ltype   = ttype;
            s.ldev    = (ttype == TT_REG_READ || ttype == TT_PLAIN_READ) ? (dev & 8'hFE) : dev;
            s.lreg    = regb;
            s.bleft   = (ttype >= TT_PLAIN_READ) ? 8'd1 : cnt;
            s.retried = 1'b0;
            s.ack     = 1'b0;
            s.stage   = SG_ADDR1;
            s = enter(s, PH_ST_A, cfg_ff);
         end
      end else if (s.phase == PH_WAITBYTE) begin
         if (kind == KIND_BYTE) begin
            s.shreg = wbyte;
            s = enter(s, PH_W_PRE, cfg_ff);
         end
      end else if (s.timer > 24'd1) begin
         s.timer = s.timer - 24'd1;
      end else begin
         s = advance(s, cfg_ff);
         if (s.phase != PH_IDLE && s.phase != PH_WAITBYTE && s.timer == 24'd0)
            s = advance(s, cfg_ff);
      end
      if (s.phase == PH_AW && !sda_in) begin
         s.ack   = 1'b1;
         s.timer = 24'd1;
      end
      eng_in = s;
      rsp_data_in = {1'b0,
                     s.done & s.ack,
                     s.done,
                     s.phase != PH_IDLE,
                     s.emit,
                     s.emit ? s.shreg : 8'd0,
                     s.phase == PH_WAITBYTE,
                     s.sda,
                     s.scl};
   end

   always_comb begin
      csr_prdata = 32'd0;
      unique case (csr_paddr[3:2])
         REG_SHORT: csr_prdata = {16'd0, cfg_ff.short_ticks};
         REG_LONG:  csr_prdata = {16'd0, cfg_ff.long_ticks};
         REG_RETRY: csr_prdata = {8'd0, cfg_ff.retry_ticks};
         REG_ACKW:  csr_prdata = {24'd0, cfg_ff.ack_ticks};
         default:   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_ticks <= 16'd6;
         cfg_ff.long_ticks  <= 16'd18;
         cfg_ff.retry_ticks <= 24'd1000;
         cfg_ff.ack_ticks   <= 8'd250;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[3:2])
            REG_SHORT: cfg_ff.short_ticks <= csr_pwdata[15:0];
            REG_LONG:  cfg_ff.long_ticks  <= csr_pwdata[15:0];
            REG_RETRY: cfg_ff.retry_ticks <= csr_pwdata[23:0];
            REG_ACKW:  cfg_ff.ack_ticks   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eng_ff       <= '{phase: PH_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         eng_ff       <= eng_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== test/tb_i2c_master_transaction_engine.sv =====
`timescale 1ns / 1ps
module tb_i2c_master_transaction_engine;
   import i2cm_pkg::*;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_SPARE = 2'd3;
   localparam logic [2:0] TT_PLAIN_WRITE = 3'd2;
   localparam int STALL_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic [1:0]  req_tuser;
   logic [39:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   i2c_master_transaction_engine dut (.*);

   // bus engine mirror
   logic [15:0] cfg_short, cfg_long;
   logic [23:0] cfg_retry;
   logic [7:0]  cfg_ackw;
   phase_type   m_ph;
   logic [23:0] m_tmr;
   logic [3:0]  m_bits;
   logic [7:0]  m_shift, m_left, m_dev, m_reg;
   logic [2:0]  m_type, m_stage;
   logic        m_retried, m_ack, m_scl, m_sda, m_sda_in, m_emit, m_done;

   logic [15:0] bus_levels_q[$];
   int          errors;
   int          send_idle_pct, recv_idle_pct;
   int          hold_cycles;
   int          stall_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [23:0] short_len();
      return (cfg_short == 16'd0) ? 24'd1 : {8'd0, cfg_short};
   endfunction

   function automatic logic [23:0] long_len();
      return (cfg_long == 16'd0) ? 24'd1 : {8'd0, cfg_long};
   endfunction

   function automatic void enter_phase(phase_type p);
      m_ph  = p;
      m_tmr = short_len();
      case (p)
         PH_ST_A: m_sda = 1'b1;
         PH_ST_B: m_scl = 1'b1;
         PH_ST_C: m_sda = 1'b0;
         PH_ST_D: m_scl = 1'b0;
         PH_W_PRE: begin
            m_scl  = 1'b0;
            m_bits = 4'd0;
         end
         PH_W_SET: m_sda = m_shift[7];
         PH_W_HIGH: begin
            m_scl = 1'b1;
            m_tmr = long_len();
         end
         PH_W_LOW: m_scl = 1'b0;
         PH_A1: begin
            m_scl = 1'b0;
            m_sda = 1'b1;
         end
         PH_A2: begin
            m_scl = 1'b1;
            m_sda = 1'b1;
         end
         PH_AW: begin
            m_ack = 1'b0;
            m_tmr = {16'd0, cfg_ackw};
         end
         PH_A3: ;
         PH_A4: m_scl = 1'b0;
         PH_R_PRE: begin
            m_sda   = 1'b1;
            m_bits  = 4'd0;
            m_shift = 8'd0;
         end
         PH_R_HIGH: begin
            m_scl   = 1'b1;
            m_shift = {m_shift[6:0], m_sda_in};
            m_bits  = m_bits + 4'd1;
            if (m_bits == 4'd8) m_emit = 1'b1;
         end
         PH_R_LOW: begin
            m_scl = 1'b0;
            m_tmr = long_len();
         end
         PH_K_SET: begin
            if (m_left != 8'd0) m_left = m_left - 8'd1;
            m_sda = (m_left == 8'd0);
         end
         PH_K_HIGH: begin
            m_scl = 1'b1;
            m_tmr = long_len();
         end
         PH_K_LOW: m_scl = 1'b0;
         PH_P_A: m_sda = 1'b0;
         PH_P_B: m_scl = 1'b1;
         PH_RETRY: m_tmr = cfg_retry;
         PH_WAITBYTE: begin
            m_scl = 1'b0;
            m_tmr = 24'd0;
         end
         default: begin
            m_ph  = PH_IDLE;
            m_scl = 1'b1;
            m_sda = 1'b1;
            m_tmr = 24'd0;
         end
      endcase
   endfunction

   function automatic void finish_bus(logic ok);
      m_ack = ok;
      enter_phase(PH_P_A);
   endfunction

   function automatic void next_write();
      m_stage = SG_WDATA;
      if (m_left == 8'd0) finish_bus(1'b1);
      else enter_phase(PH_WAITBYTE);
   endfunction

   function automatic void ack_done();
      if (!m_ack) begin
         if (m_stage == SG_ADDR1 && m_type != TT_CMD_WRITE && !m_retried) begin
            m_retried = 1'b1;
            enter_phase(PH_RETRY);
         end else begin
            finish_bus(1'b0);
         end
         return;
      end
      case (m_stage)
         SG_ADDR1: begin
            if (m_type <= TT_REG_READ) begin
               m_stage = SG_REG;
               m_shift = m_reg;
               enter_phase(PH_W_PRE);
            end else if (m_type == TT_PLAIN_READ) begin
               m_stage = SG_RADDR;
               enter_phase(PH_ST_A);
            end else begin
               next_write();
            end
         end
         SG_REG: begin
            if (m_type == TT_REG_WRITE) begin
               next_write();
            end else begin
               m_stage = SG_RADDR;
               enter_phase(PH_ST_A);
            end
         end
         SG_RADDR: begin
            if (m_left == 8'd0) begin
               finish_bus(1'b1);
            end else begin
               m_stage = SG_RDATA;
               enter_phase(PH_R_PRE);
            end
         end
         SG_WDATA: begin
            if (m_left != 8'd0) m_left = m_left - 8'd1;
            next_write();
         end
         default: finish_bus(1'b1);
      endcase
   endfunction

   function automatic void step_phase();
      case (m_ph)
         PH_ST_A: enter_phase(PH_ST_B);
         PH_ST_B: enter_phase(PH_ST_C);
         PH_ST_C: enter_phase(PH_ST_D);
         PH_ST_D: begin
            m_shift = (m_stage == SG_RADDR) ? (m_dev | 8'h01) : m_dev;
            enter_phase(PH_W_PRE);
         end
         PH_W_PRE:  enter_phase(PH_W_SET);
         PH_W_SET:  enter_phase(PH_W_HIGH);
         PH_W_HIGH: enter_phase(PH_W_LOW);
         PH_W_LOW: begin
            m_shift = {m_shift[6:0], 1'b0};
            m_bits  = m_bits + 4'd1;
            enter_phase((m_bits >= 4'd8) ? PH_A1 : PH_W_SET);
         end
         PH_A1: enter_phase(PH_A2);
         PH_A2: enter_phase(PH_AW);
         PH_AW: enter_phase(PH_A3);
         PH_A3: enter_phase(PH_A4);
         PH_A4: ack_done();
         PH_R_PRE:  enter_phase(PH_R_HIGH);
         PH_R_HIGH: enter_phase(PH_R_LOW);
         PH_R_LOW:  enter_phase((m_bits >= 4'd8) ? PH_K_SET : PH_R_HIGH);
         PH_K_SET:  enter_phase(PH_K_HIGH);
         PH_K_HIGH: enter_phase(PH_K_LOW);
         PH_K_LOW: begin
            if (m_left == 8'd0) finish_bus(1'b1);
            else enter_phase(PH_R_PRE);
         end
         PH_P_A: enter_phase(PH_P_B);
         PH_P_B: begin
            m_done = 1'b1;
            enter_phase(PH_IDLE);
         end
         PH_RETRY: begin
            m_stage = SG_ADDR1;
            enter_phase(PH_ST_A);
         end
         default: enter_phase(PH_IDLE);
      endcase
   endfunction

   function automatic logic [15:0] predict_bus_tick(logic [1:0] kind, logic [2:0] tt,
         logic [7:0] dev, logic [7:0] regb, logic [7:0] cnt, logic [7:0] wb, logic sda);
      int g;
      m_sda_in = sda;
      m_emit   = 1'b0;
      m_done   = 1'b0;
      if (m_ph == PH_IDLE) begin
         if (kind == KIND_BEGIN && tt <= TT_CMD_WRITE) begin
            m_type    = tt;
            m_dev     = (tt == TT_REG_READ || tt == TT_PLAIN_READ) ? (dev & 8'hFE) : dev;
            m_reg     = regb;
            m_left    = (tt >= TT_PLAIN_READ) ? 8'd1 : cnt;
            m_retried = 1'b0;
            m_ack     = 1'b0;
            m_stage   = SG_ADDR1;
            enter_phase(PH_ST_A);
         end
      end else if (m_ph == PH_WAITBYTE) begin
         if (kind == KIND_BYTE) begin
            m_shift = wb;
            enter_phase(PH_W_PRE);
         end
      end else if (m_tmr > 24'd1) begin
         m_tmr = m_tmr - 24'd1;
      end else begin
         step_phase();
         for (g = 0; g < 4 && m_ph != PH_IDLE && m_ph != PH_WAITBYTE && m_tmr == 24'd0; g++)
            step_phase();
      end
      if (m_ph == PH_AW && !sda) begin
         m_ack = 1'b1;
         m_tmr = 24'd1;
      end
      return {1'b0, m_done & m_ack, m_done, m_ph != PH_IDLE, m_emit,
              m_emit ? m_shift : 8'h00, m_ph == PH_WAITBYTE, m_sda, m_scl};
   endfunction

   task automatic send_tick(logic [1:0] kind, logic [2:0] tt, logic [7:0] dev,
         logic [7:0] regb, logic [7:0] cnt, logic [7:0] wb, logic sda);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(4, 1);
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  = kind;
      req_tdata  = {4'd0, sda, wb, cnt, regb, dev, tt};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bus_levels_q.push_back(predict_bus_tick(kind, tt, dev, regb, cnt, wb, sda));
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // one bus tick driven by the engine's state: answer byte requests, ack with ack_pct
   task automatic bus_tick(int ack_pct);
      logic sda;
      sda = (m_ph == PH_AW || m_ph == PH_A2) ? ($urandom_range(99) >= ack_pct)
                                             : 1'($urandom);
      if (m_ph == PH_WAITBYTE && $urandom_range(9) != 0)
         send_tick(KIND_BYTE, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), sda);
      else if ($urandom_range(9) == 0)
         send_tick(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), sda);
      else
         send_tick(KIND_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), sda);
   endtask

   task automatic run_transfer(logic [2:0] tt, logic [7:0] dev, logic [7:0] cnt,
         int ack_pct);
      send_tick(KIND_BEGIN, tt, dev, 8'($urandom), cnt, 8'($urandom), 1'($urandom));
      while (m_ph != PH_IDLE) bus_tick(ack_pct);
   endtask

   task automatic drain();
      release_req();
      while (bus_levels_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_SHORT: cfg_short = value[15:0];
         REG_LONG:  cfg_long  = value[15:0];
         REG_RETRY: cfg_retry = value[23:0];
         default:   cfg_ackw  = value[7:0];
      endcase
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata != (value & ((idx == REG_RETRY) ? 32'hFFFFFF :
                                  (idx == REG_ACKW) ? 32'hFF : 32'hFFFF))) begin
         $display("%0t register %0d readback expected %0h actual %0h", $time, idx,
                  value, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_timing(int s, int l, int r, int a);
      csr_write(REG_SHORT, s);
      csr_write(REG_LONG, l);
      csr_write(REG_RETRY, r);
      csr_write(REG_ACKW, a);
   endtask

   task automatic test_reset_timing();
      run_transfer(TT_CMD_WRITE, 8'hA5, 8'd0, 100);
      drain();
   endtask

   task automatic test_register_extremes();
      int i;
      set_timing(65535, 65535, 16777215, 255);
      for (i = 0; i < 8; i++)
         send_tick(KIND_TICK, 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 1'($urandom));
      drain();
   endtask

   task automatic test_each_transfer();
      set_timing(1, 2, 3, 4);
      run_transfer(TT_REG_WRITE, 8'h00, 8'd2, 100);
      run_transfer(TT_REG_WRITE, 8'hFF, 8'd0, 100);
      run_transfer(TT_REG_READ, 8'hFF, 8'd2, 100);
      run_transfer(TT_REG_READ, 8'h5A, 8'd0, 100);
      run_transfer(TT_PLAIN_WRITE, 8'h81, 8'd1, 100);
      run_transfer(TT_PLAIN_READ, 8'h3C, 8'd255, 100);
      run_transfer(TT_CMD_WRITE, 8'h7E, 8'd0, 100);
      run_transfer(TT_REG_WRITE, 8'h12, 8'd1, 0);
      run_transfer(TT_CMD_WRITE, 8'h34, 8'd1, 0);
      run_transfer(TT_PLAIN_WRITE, 8'h56, 8'd3, 60);
      send_tick(KIND_BEGIN, 3'd5, 8'h11, 8'h22, 8'd1, 8'h33, 1'b0);
      send_tick(KIND_BEGIN, 3'd7, 8'hEE, 8'hDD, 8'd9, 8'hCC, 1'b1);
      send_tick(KIND_SPARE, TT_REG_WRITE, 8'h01, 8'h02, 8'd1, 8'h04, 1'b0);
      send_tick(KIND_BYTE, TT_REG_WRITE, 8'h01, 8'h02, 8'd1, 8'hFF, 1'b1);
      drain();
      set_timing(0, 0, 0, 0);
      run_transfer(TT_REG_READ, 8'h91, 8'd2, 100);
      run_transfer(TT_REG_WRITE, 8'h92, 8'd2, 100);
      drain();
   endtask

   task automatic test_random_traffic(int n, int sp, int rp);
      int i;
      send_idle_pct = sp;
      recv_idle_pct = rp;
      set_timing($urandom_range(3, 1), $urandom_range(4, 1), $urandom_range(20),
                 ($urandom_range(3) == 0) ? 255 : $urandom_range(10, 1));
      for (i = 0; i < n || m_ph != PH_IDLE; i++) begin
         if (m_ph == PH_IDLE && $urandom_range(99) < 30)
            send_tick(KIND_BEGIN, ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                           : 3'($urandom_range(4)),
                      8'($urandom), 8'($urandom),
                      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3)),
                      8'($urandom), 1'($urandom));
         else
            bus_tick(85);
      end
      drain();
   endtask

   task automatic test_output_stall();
      int i;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 300;
      run_transfer(TT_REG_READ, 8'h6B, 8'd3, 100);
      for (i = 0; i < 100; i++) bus_tick(90);
      drain();
   endtask

   task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      logic [15:0] exp_v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (bus_levels_q.size() == 0) begin
            $display("%0t unexpected transfer expected none actual %0h", $time, rsp_tdata);
            errors++;
         end else begin
            exp_v = bus_levels_q.pop_front();
            check_field("scl_release", exp_v[0], rsp_tdata[0]);
            check_field("sda_release", exp_v[1], rsp_tdata[1]);
            check_field("byte_request", exp_v[2], rsp_tdata[2]);
            check_field("read_byte", exp_v[10:3], rsp_tdata[10:3]);
            check_field("read_valid", exp_v[11], rsp_tdata[11]);
            check_field("busy", exp_v[12], rsp_tdata[12]);
            check_field("done", exp_v[13], rsp_tdata[13]);
            check_field("success", exp_v[14], rsp_tdata[14]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = KIND_TICK;
      req_tdata = 40'd0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 4'd0;
      csr_pwdata = 32'd0;
      errors = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      stall_count = 0;
      cfg_short = 16'd6;
      cfg_long = 16'd18;
      cfg_retry = 24'd1000;
      cfg_ackw = 8'd250;
      m_ph = PH_IDLE;
      m_tmr = 24'd0;
      m_bits = 4'd0;
      m_shift = 8'd0;
      m_left = 8'd0;
      m_dev = 8'd0;
      m_reg = 8'd0;
      m_type = 3'd0;
      m_stage = SG_ADDR1;
      m_retried = 1'b0;
      m_ack = 1'b0;
      m_scl = 1'b1;
      m_sda = 1'b1;
      m_sda_in = 1'b0;
      m_emit = 1'b0;
      m_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_timing();
      test_register_extremes();
      test_each_transfer();
      test_random_traffic(150, 12, 60);
      test_random_traffic(150, 60, 12);
      test_random_traffic(150, 0, 0);
      test_output_stall();

      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
